// File: src/bvex_pkg.sv
// ----------------------------------------------------------------------------
// bvex_pkg: shared types and constants of the beacon vendor element extractor
// Transaction payload types, header geometry and frame-control codes.
// ----------------------------------------------------------------------------
package bvex_pkg;

  // Length arithmetic width, fixed by the frame_len field
  localparam int LEN_BITS         = 12;
  localparam int MGMT_HEADER_LEN  = 24;
  localparam int BEACON_FIXED_LEN = 12;
  localparam int FCS_LEN          = 4;

  localparam int TSTART_W = 6;
  localparam logic [TSTART_W-1:0] TAGGED_START_BASE =
    TSTART_W'(MGMT_HEADER_LEN + BEACON_FIXED_LEN);
  localparam logic [TSTART_W-1:0] ORDER_EXTRA = TSTART_W'(4);
  localparam logic [LEN_BITS-1:0] LEN_MAX     = {LEN_BITS{1'b1}};

  localparam logic [7:0] FC_TYPE_MASK  = 8'hFC;
  localparam logic [7:0] FC_BEACON     = 8'h80;
  localparam int         ORDER_BIT     = 7;
  localparam int         VENDOR_HDR_LEN = 6;
  localparam logic [7:0] OUI_PLUS_TYPE = 8'd4;

  // Element header byte indexes
  localparam logic [2:0] HDR_ID   = 3'd0;
  localparam logic [2:0] HDR_LEN  = 3'd1;
  localparam logic [2:0] HDR_OUI0 = 3'd2;
  localparam logic [2:0] HDR_OUI1 = 3'd3;
  localparam logic [2:0] HDR_OUI2 = 3'd4;
  localparam logic [2:0] HDR_TYPE = 3'd5;

  // Configuration registers
  localparam int         CFG_ADDR_W            = 3;
  localparam logic       REG_TARGET_OUI        = 1'b0;
  localparam logic       REG_TARGET_ELEMENT_ID = 1'b1;
  localparam logic [23:0] TARGET_OUI_RST        = 24'hFA0BBC;
  localparam logic [7:0]  TARGET_ELEMENT_ID_RST = 8'hDD;

  typedef struct packed {
    logic                frame_start;
    logic                is_mgmt;
    logic [LEN_BITS-1:0] frame_len;
    logic [7:0]          data_byte;
  } bvex_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first;
    logic       last;
    logic       truncated;
  } bvex_out_t;

endpackage

// File: src/beacon_vendor_element_extractor.sv
// ----------------------------------------------------------------------------
// beacon_vendor_element_extractor: vendor-specific element payload extractor
// Walks received beacon frames byte by byte and emits the payload of the
// first vendor-specific element whose OUI matches the programmed value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one received frame byte
//   per transaction; frame_start, is_mgmt and frame_len are sampled on the
//   first byte of a frame. Non-beacon and non-management frames are dropped.
//   Output channel (out_valid / out_stall / out_data): one payload byte per
//   transaction, with first, last and truncated markers.
//   Configuration: APB-style port, target_oui at 0x0, target_element_id at
//   0x4. Write only while no frame is in flight.
// Timing:
//   One input transaction per cycle while in_stall is low. Each byte is decoded
//   by a single pass of logic between the walk state registers and the output
//   register, so a payload byte reaches out_data through that register.
// Stall:
//   The output register is backed by a one-entry skid register. in_stall
//   rises only once both hold a result, i.e. in the cycle after the receiver
//   stalled with a second result on the way; no result is lost.
// Reset:
//   Synchronous, active low. Returns the walk to idle, empties both output
//   entries and restores the register defaults (OUI FA:0B:BC, id 0xDD).
// ----------------------------------------------------------------------------
module beacon_vendor_element_extractor
  import bvex_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bvex_in_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output bvex_out_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_HDR,
    PH_BODY,
    PH_PAYLOAD
  } phase_t;

  // configuration
  logic [23:0]         target_oui_r;
  logic [7:0]          target_element_id_r;

  // frame walk state
  phase_t              phase_r,       phase_nxt;
  logic [LEN_BITS-1:0] byte_pos_r,    byte_pos_nxt;
  logic [LEN_BITS-1:0] tagged_end_r,  tagged_end_nxt;
  logic [TSTART_W-1:0] tagged_start_r, tagged_start_nxt;
  logic [2:0]          hdr_idx_r,     hdr_idx_nxt;
  logic [7:0]          elem_rem_r,    elem_rem_nxt;
  logic                cand_r,        cand_nxt;
  logic [7:0]          pay_rem_r,     pay_rem_nxt;

  // output register and skid entry
  logic                out_valid_r;
  bvex_out_t           out_data_r;
  logic                skid_valid_r;
  bvex_out_t           skid_data_r;

  logic                accept;
  logic                emit;
  bvex_out_t           result;
  logic                cfg_wr;
  logic                out_free;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~skid_valid_r;
  assign out_free = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (paddr[2])
      REG_TARGET_OUI:        prdata = {8'd0, target_oui_r};
      REG_TARGET_ELEMENT_ID: prdata = {24'd0, target_element_id_r};
      default:               prdata = 32'd0;
    endcase
  end

  function automatic logic [7:0] oui_byte(input logic [23:0] oui, input logic [2:0] idx);
    case (idx)
      HDR_OUI0: oui_byte = oui[23:16];
      HDR_OUI1: oui_byte = oui[15:8];
      HDR_OUI2: oui_byte = oui[7:0];
      default:  oui_byte = 8'd0;
    endcase
  endfunction

  // Single-pass decode of one frame byte
  always_comb begin
    logic [LEN_BITS-1:0] pos;
    logic [7:0]          b;
    logic                region_ends;

    pos              = byte_pos_r;
    b                = in_data.data_byte;
    region_ends      = 1'b0;
    phase_nxt        = phase_r;
    tagged_end_nxt   = tagged_end_r;
    tagged_start_nxt = tagged_start_r;
    hdr_idx_nxt      = hdr_idx_r;
    elem_rem_nxt     = elem_rem_r;
    cand_nxt         = cand_r;
    pay_rem_nxt      = pay_rem_r;
    emit             = 1'b0;
    result           = '0;
    result.payload_byte = b;

    if (in_data.frame_start) begin
      pos              = '0;
      tagged_start_nxt = TAGGED_START_BASE;
      tagged_end_nxt   = (in_data.frame_len >= LEN_BITS'(FCS_LEN)) ?
                         in_data.frame_len - LEN_BITS'(FCS_LEN) : '0;
      hdr_idx_nxt      = HDR_ID;
      elem_rem_nxt     = '0;
      cand_nxt         = 1'b0;
      pay_rem_nxt      = '0;
      phase_nxt = (in_data.is_mgmt && ((b & FC_TYPE_MASK) == FC_BEACON)) ?
                  PH_SKIP : PH_IDLE;
    end else begin
      // order bit in second frame-control byte adds the HT control field
      if (phase_nxt == PH_SKIP && pos == LEN_BITS'(1) && b[ORDER_BIT])
        tagged_start_nxt = tagged_start_nxt + ORDER_EXTRA;
      if (phase_nxt == PH_SKIP && pos >= LEN_BITS'(tagged_start_nxt)) begin
        phase_nxt   = PH_HDR;
        hdr_idx_nxt = HDR_ID;
      end
      // walk ran off the tagged region
      if ((phase_nxt == PH_HDR || phase_nxt == PH_BODY) && pos >= tagged_end_nxt)
        phase_nxt = PH_IDLE;

      case (phase_nxt)
        PH_HDR: begin
          if (hdr_idx_nxt == HDR_ID) begin
            cand_nxt = (b == target_element_id_r) &&
                       ({1'b0, pos} + (LEN_BITS+1)'(VENDOR_HDR_LEN) < {1'b0, tagged_end_nxt});
            hdr_idx_nxt = HDR_LEN;
          end else if (hdr_idx_nxt == HDR_LEN) begin
            elem_rem_nxt = b;
            if (b < OUI_PLUS_TYPE)
              cand_nxt = 1'b0;
            if (cand_nxt)
              hdr_idx_nxt = HDR_OUI0;
            else if (b == 8'd0)
              hdr_idx_nxt = HDR_ID;
            else
              phase_nxt = PH_BODY;
          end else begin
            elem_rem_nxt = elem_rem_nxt - 8'd1;
            if (hdr_idx_nxt <= HDR_OUI2 && b != oui_byte(target_oui_r, hdr_idx_nxt))
              cand_nxt = 1'b0;
            if (hdr_idx_nxt == HDR_TYPE) begin
              pay_rem_nxt = elem_rem_nxt;
              phase_nxt   = (elem_rem_nxt == 8'd0) ? PH_IDLE : PH_PAYLOAD;
              hdr_idx_nxt = HDR_ID;
            end else if (!cand_nxt) begin
              hdr_idx_nxt = HDR_ID;
              phase_nxt   = (elem_rem_nxt == 8'd0) ? PH_HDR : PH_BODY;
            end else begin
              hdr_idx_nxt = hdr_idx_nxt + 3'd1;
            end
          end
        end
        PH_BODY: begin
          elem_rem_nxt = elem_rem_nxt - 8'd1;
          if (elem_rem_nxt == 8'd0) begin
            phase_nxt   = PH_HDR;
            hdr_idx_nxt = HDR_ID;
          end
        end
        PH_PAYLOAD: begin
          // header index doubles as the payload-begun marker
          result.first = (hdr_idx_nxt == HDR_ID);
          region_ends  = ({1'b0, pos} + (LEN_BITS+1)'(1) >= {1'b0, tagged_end_nxt});
          pay_rem_nxt  = pay_rem_nxt - 8'd1;
          result.last      = (pay_rem_nxt == 8'd0) || region_ends;
          result.truncated = result.last && (pay_rem_nxt != 8'd0);
          emit        = 1'b1;
          hdr_idx_nxt = HDR_LEN;
          if (result.last) begin
            phase_nxt   = PH_IDLE;
            hdr_idx_nxt = HDR_ID;
          end
        end
        default: ;
      endcase
    end

    // saturate on overlong frames
    byte_pos_nxt = (pos < LEN_MAX) ? pos + LEN_BITS'(1) : LEN_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_oui_r        <= TARGET_OUI_RST;
      target_element_id_r <= TARGET_ELEMENT_ID_RST;
      phase_r             <= PH_IDLE;
      byte_pos_r          <= '0;
      tagged_end_r        <= '0;
      tagged_start_r      <= '0;
      hdr_idx_r           <= HDR_ID;
      elem_rem_r          <= '0;
      cand_r              <= 1'b0;
      pay_rem_r           <= '0;
      out_valid_r         <= 1'b0;
      skid_valid_r        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_TARGET_OUI:        target_oui_r        <= pwdata[23:0];
          REG_TARGET_ELEMENT_ID: target_element_id_r <= pwdata[7:0];
          default: ;
        endcase
      end

      // advance the walk on every accepted byte
      if (accept) begin
        phase_r        <= phase_nxt;
        byte_pos_r     <= byte_pos_nxt;
        tagged_end_r   <= tagged_end_nxt;
        tagged_start_r <= tagged_start_nxt;
        hdr_idx_r      <= hdr_idx_nxt;
        elem_rem_r     <= elem_rem_nxt;
        cand_r         <= cand_nxt;
        pay_rem_r      <= pay_rem_nxt;
      end

      // output register drains first from skid, else takes the new result
      if (out_free) begin
        out_valid_r  <= skid_valid_r | (accept & emit);
        out_data_r   <= skid_valid_r ? skid_data_r : result;
        skid_valid_r <= 1'b0;
      end else if (accept & emit) begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= result;
      end
    end
  end

endmodule

// File: src/bvex_checker.sv
// ----------------------------------------------------------------------------
// bvex_checker: port-level checks of the beacon vendor element extractor
// Watches both channels and flags skid and marker inconsistencies.
// ----------------------------------------------------------------------------
module bvex_checker
  import bvex_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input bvex_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // input backpressure only with a pending output
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a held output");

  // skid fills only behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("in_stall raised without receiver stall");

  // truncation is reported with the final byte
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.truncated |-> out_data.last)
    else $error("truncated without last");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind beacon_vendor_element_extractor bvex_checker u_bvex_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of beacon_vendor_element_extractor
// Feeds received frames one byte per transaction (beacons with tagged
// elements, dropped frames and stray bytes) and checks every payload
// transaction against a cycle-free model of the element walk. Directed
// tests cover the corner cases. Random traffic then runs under three
// idle/stall mixes and several register settings.
// ----------------------------------------------------------------------------
module tb;
  import bvex_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  // Walk phases of the element extractor, mirrored by the predictor
  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_SKIP,
    WALK_HDR,
    WALK_BODY,
    WALK_PAYLOAD
  } walk_phase_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  // Clock, reset and block ports; every input is known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  bvex_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  bvex_out_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Idle mix, set per test phase
  int tx_idle_pct  = 23;
  int rx_stall_pct = 60;

  int error_count  = 0;
  int beacon_items = 0;
  int idle_cycles  = 0;

  // Expected payload transactions, oldest first
  bvex_out_t expected_payload_q[$];
  bvex_out_t head_payload;

  // Frame under construction
  octet_q_t frame_octets;

  // Predictor copy of the registers and of the walk state
  logic [23:0]       exp_oui     = TARGET_OUI_RST;
  logic [7:0]        exp_elem_id = TARGET_ELEMENT_ID_RST;
  logic [LEN_BITS-1:0] walk_pos  = '0;
  logic [LEN_BITS-1:0] walk_end  = '0;
  logic [TSTART_W-1:0] walk_start = '0;
  walk_phase_t       walk_phase  = WALK_IDLE;
  logic [2:0]        hdr_idx     = HDR_ID;
  logic [7:0]        elem_left   = '0;
  logic              candidate   = 1'b0;
  logic [7:0]        pay_left    = '0;

  beacon_vendor_element_extractor u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stall, redrawn every cycle on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Predictor: advance the walk by one accepted byte, return 1 when the byte
  // produces a payload transaction.
  // --------------------------------------------------------------------------
  function automatic bit predict_byte(input bvex_in_t it, output bvex_out_t res);
    int         p;
    bit         emit;
    logic [7:0] b;
    logic [7:0] oui_b;
    emit = 1'b0;
    res  = '0;
    b    = it.data_byte;
    if (it.frame_start) begin
      // New frame: only a management beacon leaves the idle phase
      p          = 0;
      walk_start = TAGGED_START_BASE;
      walk_end   = (it.frame_len >= FCS_LEN) ? LEN_BITS'(it.frame_len - FCS_LEN) : '0;
      hdr_idx    = HDR_ID;
      elem_left  = '0;
      candidate  = 1'b0;
      pay_left   = '0;
      walk_phase = (it.is_mgmt && (b & FC_TYPE_MASK) == FC_BEACON) ? WALK_SKIP : WALK_IDLE;
    end else begin
      p = int'(walk_pos);
      // Order bit in the second frame-control byte adds the HT control field
      if (walk_phase == WALK_SKIP && p == 1 && b[ORDER_BIT]) begin
        walk_start = walk_start + ORDER_EXTRA;
      end
      if (walk_phase == WALK_SKIP && p >= int'(walk_start)) begin
        walk_phase = WALK_HDR;
        hdr_idx    = HDR_ID;
      end
      // Any walk byte at or past the region end finishes the frame
      if ((walk_phase == WALK_HDR || walk_phase == WALK_BODY) && p >= int'(walk_end)) begin
        walk_phase = WALK_IDLE;
      end
      case (walk_phase)
        WALK_HDR: begin
          if (hdr_idx == HDR_ID) begin
            candidate = (b == exp_elem_id) && (p + VENDOR_HDR_LEN < int'(walk_end));
            hdr_idx   = HDR_LEN;
          end else if (hdr_idx == HDR_LEN) begin
            elem_left = b;
            if (b < OUI_PLUS_TYPE) candidate = 1'b0;
            if (candidate) begin
              hdr_idx = HDR_OUI0;
            end else if (b == 8'd0) begin
              hdr_idx = HDR_ID;
            end else begin
              walk_phase = WALK_BODY;
            end
          end else begin
            elem_left = elem_left - 8'd1;
            case (hdr_idx)
              HDR_OUI0: oui_b = exp_oui[23:16];
              HDR_OUI1: oui_b = exp_oui[15:8];
              default:  oui_b = exp_oui[7:0];
            endcase
            if (hdr_idx <= HDR_OUI2 && b != oui_b) candidate = 1'b0;
            if (hdr_idx == HDR_TYPE) begin
              pay_left   = elem_left;
              walk_phase = (pay_left == 8'd0) ? WALK_IDLE : WALK_PAYLOAD;
              hdr_idx    = HDR_ID;
            end else if (!candidate) begin
              hdr_idx    = HDR_ID;
              walk_phase = (elem_left == 8'd0) ? WALK_HDR : WALK_BODY;
            end else begin
              hdr_idx = hdr_idx + 3'd1;
            end
          end
        end
        WALK_BODY: begin
          elem_left = elem_left - 8'd1;
          if (elem_left == 8'd0) begin
            walk_phase = WALK_HDR;
            hdr_idx    = HDR_ID;
          end
        end
        WALK_PAYLOAD: begin
          pay_left         = pay_left - 8'd1;
          res.payload_byte = b;
          res.first        = (hdr_idx == HDR_ID);
          res.last         = (pay_left == 8'd0) || (p + 1 >= int'(walk_end));
          res.truncated    = res.last && (pay_left != 8'd0);
          emit             = 1'b1;
          // a nonzero index marks the payload as begun
          hdr_idx          = HDR_LEN;
          if (res.last) begin
            walk_phase = WALK_IDLE;
            hdr_idx    = HDR_ID;
          end
        end
        default: ;
      endcase
    end
    walk_pos = (p < int'(LEN_MAX)) ? LEN_BITS'(p + 1) : LEN_MAX;
    return emit;
  endfunction

  // --------------------------------------------------------------------------
  // Frame building
  // --------------------------------------------------------------------------
  function automatic void push_rand(input int n);
    repeat (n) frame_octets.push_back(8'($urandom));
  endfunction

  // MAC header and fixed beacon fields; order selects the longer header
  function automatic void start_beacon(input bit order);
    frame_octets.delete();
    frame_octets.push_back(FC_BEACON | 8'($urandom_range(3)));
    frame_octets.push_back({order, 7'($urandom)});
    push_rand(MGMT_HEADER_LEN - 2 + (order ? int'(ORDER_EXTRA) : 0) + BEACON_FIXED_LEN);
  endfunction

  // Tagged element; the first three body bytes carry the given OUI
  function automatic void add_element(input logic [7:0] id, input int len,
                                      input logic [23:0] oui);
    frame_octets.push_back(id);
    frame_octets.push_back(8'(len));
    for (int k = 0; k < len; k++) begin
      if (k < 3) frame_octets.push_back(oui[23 - 8*k -: 8]);
      else       frame_octets.push_back(8'($urandom));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drive one input transaction: idle at random, then hold valid and payload
  // until accepted, and record what the accepted byte should produce.
  // --------------------------------------------------------------------------
  task automatic send_item(input bvex_in_t it);
    bvex_out_t res;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (predict_byte(it, res)) expected_payload_q.push_back(res);
  endtask

  // Send the frame under construction; fields other than the byte are only
  // meaningful on the first transaction, so randomize them elsewhere
  task automatic send_frame(input bit mgmt, input int flen);
    bvex_in_t it;
    if (mgmt && (frame_octets[0] & FC_TYPE_MASK) == FC_BEACON) begin
      beacon_items += frame_octets.size();
    end
    for (int i = 0; i < frame_octets.size(); i++) begin
      it.frame_start = (i == 0);
      it.is_mgmt     = (i == 0) ? mgmt : 1'($urandom);
      it.frame_len   = (i == 0) ? LEN_BITS'(flen) : LEN_BITS'($urandom);
      it.data_byte   = frame_octets[i];
      send_item(it);
    end
  endtask

  // Bytes with no frame_start: ignored outside a frame
  task automatic send_stray(input int n);
    bvex_in_t it;
    repeat (n) begin
      it             = bvex_in_t'($urandom);
      it.frame_start = 1'b0;
      send_item(it);
    end
  endtask

  // Drop valid and hold off until every expected payload byte has arrived
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_payload_q.size() != 0) @(posedge clk);
  endtask

  // Register write (setup + access) followed by a read back of the register
  task automatic program_reg(input logic idx, input logic [23:0] val);
    logic [23:0] mask;
    mask = (idx == REG_TARGET_OUI) ? 24'hFFFFFF : 24'h0000FF;
    pause_until_drained();
    // let the last ignored byte clear the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {8'h00, val & mask};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_TARGET_OUI) exp_oui = val;
    else                       exp_elem_id = val[7:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata[23:0] & mask) !== (val & mask)) begin
      $display("%0t: register %0d read back: expected %h, actual %h",
               $time, idx, val & mask, prdata[23:0] & mask);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Reset register values: SSID, then two matching vendor elements (only the first is extracted)
  task automatic test_default_match();
    start_beacon(1'b0);
    add_element(8'h00, 5, 24'($urandom));
    add_element(exp_elem_id, 10, exp_oui);
    add_element(exp_elem_id, 6, exp_oui);
    push_rand(FCS_LEN);
    send_frame(1'b1, frame_octets.size());
  endtask

  // Non-management frame, other subtype, stray bytes: all dropped
  task automatic test_dropped_frames();
    send_stray(3);
    start_beacon(1'b0);
    add_element(exp_elem_id, 8, exp_oui);
    push_rand(FCS_LEN);
    send_frame(1'b0, frame_octets.size());
    frame_octets[0] = 8'h84;
    send_frame(1'b1, frame_octets.size());
    send_stray(2);
  endtask

  // Order bit set: the tagged region starts four bytes later
  task automatic test_order_bit();
    start_beacon(1'b1);
    add_element(exp_elem_id, 5, exp_oui);
    push_rand(FCS_LEN);
    send_frame(1'b1, frame_octets.size());
  endtask

  // Length four finishes the frame with no payload; below four is skipped
  task automatic test_element_lengths();
    start_beacon(1'b0);
    add_element(exp_elem_id, 4, exp_oui);
    add_element(exp_elem_id, 8, exp_oui);
    push_rand(FCS_LEN);
    send_frame(1'b1, frame_octets.size());
    start_beacon(1'b0);
    add_element(exp_elem_id, 3, exp_oui);
    add_element(8'h30, 0, 24'h0);
    add_element(exp_elem_id, 7, exp_oui);
    push_rand(FCS_LEN);
    send_frame(1'b1, frame_octets.size());
  endtask

  // One wrong OUI byte at each position, then a match
  task automatic test_oui_mismatch();
    start_beacon(1'b0);
    add_element(exp_elem_id, 8, exp_oui ^ 24'h010000);
    add_element(exp_elem_id, 8, exp_oui ^ 24'h000100);
    add_element(exp_elem_id, 8, exp_oui ^ 24'h000001);
    add_element(exp_elem_id, 9, exp_oui);
    push_rand(FCS_LEN);
    send_frame(1'b1, frame_octets.size());
  endtask

  // Region end inside the payload, on the header, and right after it
  task automatic test_region_end();
    int hdr_at;
    start_beacon(1'b0);
    hdr_at = frame_octets.size();
    add_element(exp_elem_id, 20, exp_oui);
    push_rand(FCS_LEN);
    send_frame(1'b1, hdr_at + VENDOR_HDR_LEN + 5 + FCS_LEN);
    send_frame(1'b1, hdr_at + VENDOR_HDR_LEN + FCS_LEN);
    send_frame(1'b1, hdr_at + VENDOR_HDR_LEN + 1 + FCS_LEN);
  endtask

  // Lengths up to the FCS length, a region with no elements, and the longest length
  task automatic test_short_frames();
    start_beacon(1'b0);
    add_element(exp_elem_id, 10, exp_oui);
    push_rand(FCS_LEN);
    for (int n = 0; n <= FCS_LEN; n++) send_frame(1'b1, n);
    send_frame(1'b1, MGMT_HEADER_LEN + BEACON_FIXED_LEN + FCS_LEN);
    send_frame(1'b1, int'(LEN_MAX));
  endtask

  // All-zero and all-one register values, longest element on the latter
  task automatic test_register_extremes();
    program_reg(REG_TARGET_OUI, 24'h000000);
    program_reg(REG_TARGET_ELEMENT_ID, 24'h000000);
    start_beacon(1'b0);
    add_element(8'h00, 6, 24'h000000);
    push_rand(FCS_LEN);
    send_frame(1'b1, frame_octets.size());
    program_reg(REG_TARGET_OUI, 24'hFFFFFF);
    program_reg(REG_TARGET_ELEMENT_ID, 24'h0000FF);
    start_beacon(1'b0);
    add_element(8'hFF, 255, 24'hFFFFFF);
    push_rand(FCS_LEN);
    send_frame(1'b1, frame_octets.size());
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly well-formed beacons with a random element mix,
  // plus dropped frames, stray bytes, short lengths and cut-off frames.
  // Only beacon bytes count toward the item target.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [23:0] oui, input logic [7:0] id,
                                     input int target);
    int start_count;
    int kind;
    int choice;
    int len;
    int cut;
    int flen;
    program_reg(REG_TARGET_OUI, oui);
    program_reg(REG_TARGET_ELEMENT_ID, {16'h0, id});
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start_count  = beacon_items;
    while (beacon_items - start_count < target) begin
      if ($urandom_range(19) == 0) pause_until_drained();
      kind = $urandom_range(99);
      if (kind < 6) begin
        send_stray($urandom_range(1, 6));
      end else if (kind < 16) begin
        frame_octets.delete();
        push_rand($urandom_range(1, 60));
        send_frame((kind < 11) ? 1'b0 : 1'($urandom), frame_octets.size());
      end else begin
        start_beacon($urandom_range(3) == 0);
        repeat ($urandom_range(0, 4)) begin
          choice = $urandom_range(99);
          len    = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(4, 24);
          if (choice < 45)      add_element(exp_elem_id, len, exp_oui);
          else if (choice < 60) add_element(exp_elem_id, len,
                                            exp_oui ^ (24'h1 << $urandom_range(23)));
          else if (choice < 70) add_element(exp_elem_id, $urandom_range(0, 3), exp_oui);
          else                  add_element(8'($urandom), $urandom_range(0, 30),
                                            24'($urandom));
        end
        push_rand(FCS_LEN);
        flen = frame_octets.size();
        case ($urandom_range(9))
          0:       flen = $urandom_range(0, frame_octets.size());
          1:       flen = $urandom_range(0, int'(LEN_MAX));
          default: ;
        endcase
        // occasionally cut the frame off before its end
        if ($urandom_range(9) == 0) begin
          cut = $urandom_range(1, frame_octets.size());
          frame_octets = frame_octets[0:cut-1];
        end
        send_frame(1'b1, flen);
        if ($urandom_range(4) == 0) send_stray($urandom_range(1, 4));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted payload transaction with the
  // oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_payload_q.size() == 0) begin
        $display("%0t: unexpected payload transaction: expected none, actual %h %b%b%b",
                 $time, out_data.payload_byte, out_data.first, out_data.last,
                 out_data.truncated);
        error_count++;
      end else begin
        head_payload = expected_payload_q.pop_front();
        if (out_data.payload_byte !== head_payload.payload_byte ||
            out_data.first !== head_payload.first ||
            out_data.last !== head_payload.last ||
            out_data.truncated !== head_payload.truncated) begin
          $display("%0t: payload mismatch: expected %h %b %b %b, actual %h %b %b %b",
                   $time, head_payload.payload_byte, head_payload.first,
                   head_payload.last, head_payload.truncated, out_data.payload_byte,
                   out_data.first, out_data.last, out_data.truncated);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** beacon_vendor_element_extractor: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct  = 23;
    rx_stall_pct = 60;
    test_default_match();
    test_dropped_frames();
    test_order_bit();
    test_element_lengths();
    test_oui_mismatch();
    test_region_end();
    test_short_frames();
    test_register_extremes();

    test_random_traffic(23, 60, 24'($urandom), 8'($urandom), 130);
    test_random_traffic(60, 23, 24'hFFFFFF, 8'hFF, 130);
    test_random_traffic(0, 0, TARGET_OUI_RST, TARGET_ELEMENT_ID_RST, 130);

    pause_until_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_payload_q.size() == 0) begin
      $display("** beacon_vendor_element_extractor: PASSED **");
    end else begin
      $display("** beacon_vendor_element_extractor: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
src/bvex_pkg.sv
src/beacon_vendor_element_extractor.sv
src/bvex_checker.sv
dv/tb.sv
